// ----- src/wheel_speed_steer_distributor_macros.svh -----
// Assertion macros for the wheel speed and steer distributor.
// No dependencies; included by the files that carry assertions.
`ifndef WHEEL_SPEED_STEER_DISTRIBUTOR_MACROS_SVH
`define WHEEL_SPEED_STEER_DISTRIBUTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSSD_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSSD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/wssd_pkg.sv -----
// Shared constants, types and helper functions of the wheel speed and steer distributor.
// No dependencies; used by wssd_wheel and the top level.
`timescale 1ns / 1ps

package wssd_pkg;

  // Pipeline depth figures.
  localparam int CORDIC_STAGES = 16;
  localparam int ROOT_STEPS    = 32;
  localparam int CORE_LEN      = (CORDIC_STAGES > ROOT_STEPS) ? CORDIC_STAGES : ROOT_STEPS;
  localparam int DIV_STEPS     = 32;
  localparam int WHEEL_LAT     = CORE_LEN + DIV_STEPS + 10;

  // Datapath widths.
  localparam int CMD_W   = 32;
  localparam int SPIN_W  = 32;
  localparam int STEER_W = 15;
  localparam int DIST_W  = 16;
  localparam int SPAN_W  = 17;
  localparam int GEO_W   = 32;
  localparam int ABS_W   = 48;
  localparam int NORM_W  = 31;
  localparam int SQ_W    = 62;
  localparam int RAD_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int REM_W   = 35;
  localparam int CX_W    = 35;
  localparam int CZ_W    = 33;
  localparam int MAG_W   = 50;
  localparam int SHIFT_W = 7;
  localparam int DREM_W  = 16;

  localparam logic [STEER_W-1:0] STEER_MAX = 15'd12868;
  localparam logic [SPIN_W-1:0]  SPIN_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [SPIN_W-1:0]  SPIN_NEG_MAX = 32'h8000_0000;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GEO_FL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GEO_FR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GEO_RL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GEO_RR = 3'd5;

  // Drive modes and reset values.
  localparam logic [1:0] MODE_ALL   = 2'd1;
  localparam logic [1:0] MODE_FRONT = 2'd2;
  localparam logic [1:0]        MODE_RST   = MODE_ALL;
  localparam logic [DIST_W-1:0] RADIUS_RST = 16'd410;
  localparam logic [GEO_W-1:0]  GEO_RST    = 32'h0666_04CD;

  // How one wheel's result is formed.
  typedef enum logic [1:0] {
    WK_ZERO,
    WK_FIXED,
    WK_CENTRE,
    WK_STEER
  } wheel_kind_t;

  // Per-wheel command from the decode logic.
  typedef struct packed {
    logic              steer_en;
    logic              kill;
    logic              right;
    logic              rear_neg;
    logic [SPAN_W-1:0] span;
    logic [DIST_W-1:0] lat;
  } wheel_cmd_t;

  // Per-wheel control that travels with the data.
  typedef struct packed {
    wheel_kind_t               kind;
    logic                      neg;
    logic                      ang_neg;
    logic [MAG_W-1:0]          mag;
    logic signed [SHIFT_W-1:0] sft;
  } wheel_ctl_t;

  // Control that travels through the divider.
  typedef struct packed {
    logic                      neg;
    logic                      zero;
    logic                      ovf;
    logic                      mag_zero;
    logic signed [STEER_W-1:0] steer;
  } div_ctl_t;

  // Truncated arctangent of 2^-i in Q30 for the first ten steps.
  localparam logic [30:0] ATAN_Q30 [10] = '{
    31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
    31'd33543515,  31'd16775850,  31'd8388437,   31'd4194282,   31'd2097149
  };

  function automatic logic signed [CZ_W-1:0] atan_step(input int i);
    logic signed [CZ_W-1:0] res;
    if (i < 10) begin
      res = $signed({2'b00, ATAN_Q30[i]});
    end else if (i < 30) begin
      res = CZ_W'((1 << (30 - i)) - 1);
    end else begin
      res = '0;
    end
    return res;
  endfunction

  // Index of the highest set bit of a 24-bit word, with a nonzero flag on top.
  function automatic logic [5:0] msb24(input logic [23:0] x);
    logic [4:0] idx;
    logic       any;
    idx = '0;
    any = 1'b0;
    for (int i = 0; i < 24; i++) begin
      if (x[i]) begin
        idx = 5'(i);
        any = 1'b1;
      end
    end
    return {any, idx};
  endfunction

endpackage

// ----- src/wssd_wheel.sv -----
// One wheel's datapath: products, normalization, square root, CORDIC angle, divide by radius.
// Depends on wssd_pkg; all stages advance together on en.
`timescale 1ns / 1ps

module wssd_wheel (
  input  logic                              clk,
  input  logic                              en,
  input  wssd_pkg::wheel_cmd_t              cmd,
  input  logic signed [wssd_pkg::CMD_W-1:0] body_speed,
  input  logic signed [wssd_pkg::CMD_W-1:0] body_yaw_rate,
  input  logic [wssd_pkg::DIST_W-1:0]       radius,
  output logic signed [wssd_pkg::SPIN_W-1:0]  spin,
  output logic signed [wssd_pkg::STEER_W-1:0] steer,
  output logic                              fault
);
  import wssd_pkg::*;

  // Stage 1: scaled speed and the two products with the yaw rate.
  logic signed [43:0] vq_r;
  logic signed [48:0] aw_r;
  logic signed [49:0] a_r;
  wheel_cmd_t         c1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      vq_r <= {body_speed, 12'b0};
      aw_r <= $signed({1'b0, cmd.lat}) * body_yaw_rate;
      a_r  <= $signed({1'b0, cmd.span}) * body_yaw_rate;
      c1_r <= cmd;
    end
  end

  // Stage 2: numerator and magnitudes.
  logic signed [49:0] vq_x, aw_x, n_c, na_c, aa_c;
  logic [ABS_W-1:0]   ux2_r, uy2_r;
  logic               n_neg2_r, a_neg2_r;
  wheel_cmd_t         c2_r;

  assign vq_x = 50'(vq_r);
  assign aw_x = 50'(aw_r);
  assign n_c  = c1_r.right ? (vq_x + aw_x) : (vq_x - aw_x);
  assign na_c = n_c[49] ? -n_c : n_c;
  assign aa_c = a_r[49] ? -a_r : a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ux2_r    <= na_c[ABS_W-1:0];
      uy2_r    <= aa_c[ABS_W-1:0];
      n_neg2_r <= n_c[49];
      a_neg2_r <= a_r[49];
      c2_r     <= c1_r;
    end
  end

  // Stage 3: classify the wheel and search the top bit in two halves.
  wheel_ctl_t       k3_c, k3_r;
  logic [ABS_W-1:0] m3_c;
  logic [5:0]       hi3_c, lo3_c;
  logic [ABS_W-1:0] ux3_r, uy3_r;
  logic [5:0]       hi3_r;
  logic [4:0]       lo3_r;

  always_comb begin
    k3_c         = '0;
    k3_c.kind    = WK_STEER;
    k3_c.neg     = n_neg2_r;
    k3_c.ang_neg = (a_neg2_r ^ n_neg2_r) ^ c2_r.rear_neg;
    priority if (c2_r.kill) begin
      k3_c.kind = WK_ZERO;
    end else if (!c2_r.steer_en) begin
      k3_c.kind = WK_FIXED;
      k3_c.mag  = MAG_W'(ux2_r);
    end else if (ux2_r == '0) begin
      if (c2_r.span == '0) begin
        k3_c.kind = WK_ZERO;
      end else begin
        k3_c.kind    = WK_CENTRE;
        k3_c.mag     = MAG_W'(uy2_r);
        k3_c.neg     = a_neg2_r;
        k3_c.ang_neg = c2_r.rear_neg;
      end
    end else begin
      k3_c.kind = WK_STEER;
    end
    m3_c  = (ux2_r > uy2_r) ? ux2_r : uy2_r;
    hi3_c = msb24(m3_c[47:24]);
    lo3_c = msb24(m3_c[23:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k3_r  <= k3_c;
      ux3_r <= ux2_r;
      uy3_r <= uy2_r;
      hi3_r <= hi3_c;
      lo3_r <= lo3_c[4:0];
    end
  end

  // Stage 4: shift that puts the larger magnitude in [2^30, 2^31).
  logic signed [SHIFT_W-1:0] p4_c;
  wheel_ctl_t                k4_c;
  wheel_ctl_t                k4_r;
  logic [ABS_W-1:0]          ux4_r, uy4_r;

  assign p4_c = hi3_r[5] ? ($signed({2'b00, hi3_r[4:0]}) + 7'sd24)
                         : $signed({2'b00, lo3_r});

  always_comb begin
    k4_c     = k3_r;
    k4_c.sft = p4_c - 7'sd30;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k4_r     <= k4_c;
      ux4_r    <= ux3_r;
      uy4_r    <= uy3_r;
    end
  end

  // Stage 5: normalize both magnitudes.
  logic signed [SHIFT_W-1:0] nsft4_c;
  logic [5:0]                amt4_c;
  logic [ABS_W-1:0]          xs4_c, ys4_c;
  logic [NORM_W-1:0]         x5_r, y5_r;
  wheel_ctl_t                k5_r;

  assign nsft4_c = -k4_r.sft;
  assign amt4_c  = (k4_r.sft > 0) ? k4_r.sft[5:0] : nsft4_c[5:0];
  assign xs4_c   = (k4_r.sft > 0) ? (ux4_r >> amt4_c) : (ux4_r << amt4_c);
  assign ys4_c   = (k4_r.sft > 0) ? (uy4_r >> amt4_c) : (uy4_r << amt4_c);

  always_ff @(posedge clk) begin
    if (en) begin
      x5_r <= xs4_c[NORM_W-1:0];
      y5_r <= ys4_c[NORM_W-1:0];
      k5_r <= k4_r;
    end
  end

  // Stage 6: squares.
  logic [SQ_W-1:0]   sqx6_r, sqy6_r;
  logic [NORM_W-1:0] x6_r, y6_r;
  wheel_ctl_t        k6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx6_r <= x5_r * x5_r;
      sqy6_r <= y5_r * y5_r;
      x6_r   <= x5_r;
      y6_r   <= y5_r;
      k6_r   <= k5_r;
    end
  end

  // Core: one root digit per stage, and one CORDIC rotation in each of the first CORDIC_STAGES stages.
  logic [RAD_W-1:0]       rad_r  [CORE_LEN+1];
  logic [REM_W-1:0]       rem_r  [CORE_LEN+1];
  logic [ROOT_W-1:0]      root_r [CORE_LEN+1];
  logic signed [CX_W-1:0] cx_r   [CORE_LEN+1];
  logic signed [CX_W-1:0] cy_r   [CORE_LEN+1];
  logic signed [CZ_W-1:0] cz_r   [CORE_LEN+1];
  logic                   yz_r   [CORE_LEN+1];
  wheel_ctl_t             kc_r   [CORE_LEN+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= RAD_W'(sqx6_r) + RAD_W'(sqy6_r);
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      cx_r[0]   <= $signed({4'b0000, x6_r});
      cy_r[0]   <= $signed({4'b0000, y6_r});
      cz_r[0]   <= '0;
      yz_r[0]   <= (y6_r == '0);
      kc_r[0]   <= k6_r;
    end
  end

  for (genvar j = 0; j < CORE_LEN; j++) begin : g_core
    logic [RAD_W-1:0]       rad_nxt;
    logic [REM_W-1:0]       rem_nxt;
    logic [ROOT_W-1:0]      root_nxt;
    logic signed [CX_W-1:0] cx_nxt, cy_nxt;
    logic signed [CZ_W-1:0] cz_nxt;

    if (j < ROOT_STEPS) begin : g_root
      logic [REM_W-1:0] trial, sub;
      always_comb begin
        trial   = {rem_r[j][REM_W-3:0], rad_r[j][RAD_W-1 -: 2]};
        sub     = REM_W'({root_r[j], 2'b01});
        rad_nxt = rad_r[j] << 2;
        if (trial >= sub) begin
          rem_nxt  = trial - sub;
          root_nxt = {root_r[j][ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = trial;
          root_nxt = {root_r[j][ROOT_W-2:0], 1'b0};
        end
      end
    end else begin : g_root_hold
      assign rad_nxt  = rad_r[j];
      assign rem_nxt  = rem_r[j];
      assign root_nxt = root_r[j];
    end

    if (j < CORDIC_STAGES) begin : g_rot
      localparam logic signed [CZ_W-1:0] ATAN_J = atan_step(j);
      always_comb begin
        if (!cy_r[j][CX_W-1]) begin
          cx_nxt = cx_r[j] + (cy_r[j] >>> j);
          cy_nxt = cy_r[j] - (cx_r[j] >>> j);
          cz_nxt = cz_r[j] + ATAN_J;
        end else begin
          cx_nxt = cx_r[j] - (cy_r[j] >>> j);
          cy_nxt = cy_r[j] + (cx_r[j] >>> j);
          cz_nxt = cz_r[j] - ATAN_J;
        end
      end
    end else begin : g_rot_hold
      assign cx_nxt = cx_r[j];
      assign cy_nxt = cy_r[j];
      assign cz_nxt = cz_r[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[j+1]  <= rad_nxt;
        rem_r[j+1]  <= rem_nxt;
        root_r[j+1] <= root_nxt;
        cx_r[j+1]   <= cx_nxt;
        cy_r[j+1]   <= cy_nxt;
        cz_r[j+1]   <= cz_nxt;
        yz_r[j+1]   <= yz_r[j];
        kc_r[j+1]   <= kc_r[j];
      end
    end
  end

  // Back end: undo the normalization on the root and finish the angle.
  wheel_ctl_t                kb_c;
  logic signed [SHIFT_W-1:0] nsftb_c;
  logic [5:0]                amtb_c;
  logic [MAG_W-1:0]          hb_c, magb_c;
  logic signed [CZ_W-1:0]    zr_c, q_c;
  logic [STEER_W-1:0]        ang_c, angk_c;
  logic [MAG_W-1:0]          magb_r;
  logic                      negb_r, zerob_r;
  logic signed [STEER_W-1:0] steerb_r;

  always_comb begin
    kb_c    = kc_r[CORE_LEN];
    nsftb_c = -kb_c.sft;
    amtb_c  = (kb_c.sft > 0) ? kb_c.sft[5:0] : nsftb_c[5:0];
    hb_c    = (kb_c.sft > 0) ? (MAG_W'(root_r[CORE_LEN]) << amtb_c)
                             : (MAG_W'(root_r[CORE_LEN]) >> amtb_c);
    magb_c  = (kb_c.kind == WK_STEER) ? hb_c : kb_c.mag;
    zr_c    = cz_r[CORE_LEN] + 33'sd65536;
    q_c     = zr_c >>> 17;
    priority if (yz_r[CORE_LEN] || (q_c < 0)) begin
      ang_c = '0;
    end else if (q_c > $signed({18'b0, STEER_MAX})) begin
      ang_c = STEER_MAX;
    end else begin
      ang_c = q_c[STEER_W-1:0];
    end
    unique case (kb_c.kind)
      WK_STEER:  angk_c = ang_c;
      WK_CENTRE: angk_c = STEER_MAX;
      default:   angk_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      magb_r   <= magb_c;
      negb_r   <= kb_c.neg;
      zerob_r  <= (kb_c.kind == WK_ZERO);
      steerb_r <= kb_c.ang_neg ? -$signed(angk_c) : $signed(angk_c);
    end
  end

  // Divider setup: the quotient fits 32 bits unless the top bits reach the radius.
  logic [DREM_W-1:0] drem_r [DIV_STEPS+1];
  logic [SPIN_W-1:0] dvd_r  [DIV_STEPS+1];
  div_ctl_t          dc_r   [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      drem_r[0]        <= magb_r[47:32];
      dvd_r[0]         <= magb_r[31:0];
      dc_r[0].neg      <= negb_r;
      dc_r[0].zero     <= zerob_r;
      dc_r[0].ovf      <= (magb_r[MAG_W-1:32] >= {2'b00, radius});
      dc_r[0].mag_zero <= (magb_r == '0);
      dc_r[0].steer    <= steerb_r;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar d = 0; d < DIV_STEPS; d++) begin : g_div
    logic [DREM_W:0]   trial;
    logic [DREM_W:0]   diff;
    logic              take;
    assign trial = {drem_r[d], dvd_r[d][SPIN_W-1]};
    assign diff  = trial - {1'b0, radius};
    assign take  = (trial >= {1'b0, radius});

    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[d+1] <= take ? diff[DREM_W-1:0] : trial[DREM_W-1:0];
        dvd_r[d+1]  <= {dvd_r[d][SPIN_W-2:0], take};
        dc_r[d+1]   <= dc_r[d];
      end
    end
  end

  // Final stage: sign, saturation and fault.
  div_ctl_t          df_c;
  logic [SPIN_W-1:0] qf_c, spin_c;
  logic              fault_c;
  logic [SPIN_W-1:0] spin_r;
  logic signed [STEER_W-1:0] steer_r;
  logic              fault_r;

  always_comb begin
    df_c    = dc_r[DIV_STEPS];
    qf_c    = dvd_r[DIV_STEPS];
    fault_c = 1'b0;
    priority if (df_c.zero) begin
      spin_c  = '0;
      fault_c = 1'b1;
    end else if (radius == '0) begin
      fault_c = 1'b1;
      spin_c  = df_c.mag_zero ? '0 : (df_c.neg ? SPIN_NEG_MAX : SPIN_POS_MAX);
    end else if (df_c.ovf) begin
      fault_c = 1'b1;
      spin_c  = df_c.neg ? SPIN_NEG_MAX : SPIN_POS_MAX;
    end else if (!df_c.neg) begin
      if (qf_c[SPIN_W-1]) begin
        fault_c = 1'b1;
        spin_c  = SPIN_POS_MAX;
      end else begin
        spin_c  = qf_c;
      end
    end else begin
      if (qf_c > SPIN_NEG_MAX) begin
        fault_c = 1'b1;
        spin_c  = SPIN_NEG_MAX;
      end else begin
        spin_c  = '0 - qf_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spin_r  <= spin_c;
      steer_r <= df_c.steer;
      fault_r <= fault_c;
    end
  end

  assign spin  = $signed(spin_r);
  assign steer = steer_r;
  assign fault = fault_r;

endmodule

// ----- src/wheel_speed_steer_distributor.sv -----
// CORE_LEN = max(32, CORDIC_STAGES) sets the length of the root and CORDIC core.
// One request per cycle while not stalled; root, CORDIC and divider are fully pipelined.
// The whole pipeline holds while a finished result waits on out_ready.
// Reset (synchronous, rst_n low) clears the valid bits and loads the register defaults.
// Depends on wssd_pkg and wssd_wheel; assertions use the macros header.
`timescale 1ns / 1ps
`include "wheel_speed_steer_distributor_macros.svh"

module wheel_speed_steer_distributor (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [wssd_pkg::CMD_W-1:0]   in_body_speed,
  input  logic signed [wssd_pkg::CMD_W-1:0]   in_body_yaw_rate,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [wssd_pkg::SPIN_W-1:0]  out_front_left_spin,
  output logic signed [wssd_pkg::SPIN_W-1:0]  out_front_right_spin,
  output logic signed [wssd_pkg::SPIN_W-1:0]  out_rear_left_spin,
  output logic signed [wssd_pkg::SPIN_W-1:0]  out_rear_right_spin,
  output logic signed [wssd_pkg::STEER_W-1:0] out_front_left_steer,
  output logic signed [wssd_pkg::STEER_W-1:0] out_front_right_steer,
  output logic signed [wssd_pkg::STEER_W-1:0] out_rear_left_steer,
  output logic signed [wssd_pkg::STEER_W-1:0] out_rear_right_steer,
  output logic                                out_fault,
  input  logic                                cfg_we,
  input  logic [wssd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wssd_pkg::GEO_W-1:0]          cfg_data
);
  import wssd_pkg::*;

  // Configuration registers.
  logic [1:0]        mode_r;
  logic [DIST_W-1:0] radius_r;
  logic [GEO_W-1:0]  geo_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RST;
      radius_r <= RADIUS_RST;
      geo_r[0] <= GEO_RST;
      geo_r[1] <= GEO_RST;
      geo_r[2] <= GEO_RST;
      geo_r[3] <= GEO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:   mode_r   <= cfg_data[1:0];
        CFG_RADIUS: radius_r <= cfg_data[DIST_W-1:0];
        CFG_GEO_FL: geo_r[0] <= cfg_data;
        CFG_GEO_FR: geo_r[1] <= cfg_data;
        CFG_GEO_RL: geo_r[2] <= cfg_data;
        CFG_GEO_RR: geo_r[3] <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Pipeline advance: everything moves unless a result is held at the output.
  logic en;
  logic vld_r [WHEEL_LAT];

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[WHEEL_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WHEEL_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < WHEEL_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // Per-wheel command decode from mode, geometry and whether the yaw rate is zero.
  wheel_cmd_t cmd_c [4];
  logic       mode_ok_c, turning_c;

  assign mode_ok_c = (mode_r == MODE_ALL) || (mode_r == MODE_FRONT);
  assign turning_c = (in_body_yaw_rate != '0);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cmd_c[k].lat      = geo_r[k][DIST_W-1:0];
      cmd_c[k].right    = k[0];
      cmd_c[k].kill     = !mode_ok_c;
      cmd_c[k].rear_neg = (mode_r == MODE_ALL) && (k >= 2);
      cmd_c[k].steer_en = turning_c &&
                          ((mode_r == MODE_ALL) || ((mode_r == MODE_FRONT) && (k < 2)));
      if ((mode_r == MODE_FRONT) && (k < 2)) begin
        cmd_c[k].span = SPAN_W'(geo_r[k][GEO_W-1:DIST_W]) +
                        SPAN_W'(geo_r[k+2][GEO_W-1:DIST_W]);
      end else begin
        cmd_c[k].span = SPAN_W'(geo_r[k][GEO_W-1:DIST_W]);
      end
    end
  end

  // Four wheel datapaths.
  logic signed [SPIN_W-1:0]  spin_w  [4];
  logic signed [STEER_W-1:0] steer_w [4];
  logic                      fault_w [4];

  for (genvar k = 0; k < 4; k++) begin : g_wheel
    wssd_wheel u_wheel (
      .clk           (clk),
      .en            (en),
      .cmd           (cmd_c[k]),
      .body_speed    (in_body_speed),
      .body_yaw_rate (in_body_yaw_rate),
      .radius        (radius_r),
      .spin          (spin_w[k]),
      .steer         (steer_w[k]),
      .fault         (fault_w[k])
    );
  end

  assign out_front_left_spin   = spin_w[0];
  assign out_front_right_spin  = spin_w[1];
  assign out_rear_left_spin    = spin_w[2];
  assign out_rear_right_spin   = spin_w[3];
  assign out_front_left_steer  = steer_w[0];
  assign out_front_right_steer = steer_w[1];
  assign out_rear_left_steer   = steer_w[2];
  assign out_rear_right_steer  = steer_w[3];
  assign out_fault             = fault_w[0] | fault_w[1] | fault_w[2] | fault_w[3];

  // Checks on the pipeline control and the angle clamp.
  `WSSD_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && in_ready, vld_r[0], "accepted request did not enter the pipeline")
  `WSSD_ASSERT_NOW(a_stall_blocks, clk, rst_n, out_valid && !out_ready, !in_ready, "input taken while the output is held")
  `WSSD_ASSERT_NOW(a_fl_range, clk, rst_n, out_valid, (out_front_left_steer <= $signed(STEER_MAX)) && (out_front_left_steer >= -$signed(STEER_MAX)), "front left steer out of range")
  `WSSD_ASSERT_NOW(a_rr_range, clk, rst_n, out_valid, (out_rear_right_steer <= $signed(STEER_MAX)) && (out_rear_right_steer >= -$signed(STEER_MAX)), "rear right steer out of range")

endmodule

// ----- verif/tb_wheel_speed_steer_distributor.sv -----
// Self-checking testbench for the wheel speed and steer distributor.
// Depends on wssd_pkg and the wheel_speed_steer_distributor RTL, with its wssd_wheel and macros header.
`timescale 1ns / 1ps

module tb_wheel_speed_steer_distributor;
  import wssd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = WHEEL_LAT + 40;

  // One expected wheel set for one request.
  typedef struct {
    logic signed [SPIN_W-1:0]  spin [4];
    logic signed [STEER_W-1:0] steer [4];
    logic                      fault;
  } wheel_set_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [CMD_W-1:0] in_body_speed;
  logic signed [CMD_W-1:0] in_body_yaw_rate;
  logic out_valid;
  logic out_ready;
  logic signed [SPIN_W-1:0]  out_front_left_spin, out_front_right_spin;
  logic signed [SPIN_W-1:0]  out_rear_left_spin, out_rear_right_spin;
  logic signed [STEER_W-1:0] out_front_left_steer, out_front_right_steer;
  logic signed [STEER_W-1:0] out_rear_left_steer, out_rear_right_steer;
  logic out_fault;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GEO_W-1:0]     cfg_data;

  // Mirror of the configuration registers.
  logic [1:0]        mode_mirror;
  logic [DIST_W-1:0] radius_mirror;
  logic [GEO_W-1:0]  geo_mirror [4];

  wheel_set_t pending_sets [$];
  int  mismatch_count;
  int  cycle_count;
  bit  steady_flow;
  bit  hold_request;

  wheel_speed_steer_distributor uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_body_speed         (in_body_speed),
    .in_body_yaw_rate      (in_body_yaw_rate),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_front_left_spin   (out_front_left_spin),
    .out_front_right_spin  (out_front_right_spin),
    .out_rear_left_spin    (out_rear_left_spin),
    .out_rear_right_spin   (out_rear_right_spin),
    .out_front_left_steer  (out_front_left_steer),
    .out_front_right_steer (out_front_right_steer),
    .out_rear_left_steer   (out_rear_left_steer),
    .out_rear_right_steer  (out_rear_right_steer),
    .out_fault             (out_fault),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  // Clock with a 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturating division of a magnitude by the wheel radius, then signed.
  function automatic logic [SPIN_W-1:0] radius_divide(input longint unsigned mag, input bit neg,
                                                      input logic [DIST_W-1:0] r,
                                                      inout bit flt);
    longint unsigned q;
    if (r == 0) begin
      flt = 1'b1;
      if (mag == 0) return '0;
      return neg ? SPIN_NEG_MAX : SPIN_POS_MAX;
    end
    q = mag / longint'(r);
    if (!neg) begin
      if (q > 64'h7FFF_FFFF) begin
        flt = 1'b1;
        return SPIN_POS_MAX;
      end
      return q[31:0];
    end
    if (q > 64'h8000_0000) begin
      flt = 1'b1;
      return SPIN_NEG_MAX;
    end
    return 32'd0 - q[31:0];
  endfunction

  // Floor square root, one result bit per pass.
  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Vectoring rotations that drive y to zero and sum the turned angle.
  function automatic logic [STEER_W-1:0] vector_angle(input longint x, input longint y);
    longint z, xs, ys, step, q;
    z = 0;
    if (y == 0) return '0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (i < 10) step = longint'(ATAN_Q30[i]);
      else if (i < 30) step = (64'sd1 <<< (30 - i)) - 1;
      else step = 0;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + step;
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - step;
      end
    end
    q = (z + 65536) >>> 17;
    if (q < 0) q = 0;
    if (q > STEER_MAX) q = STEER_MAX;
    return q[STEER_W-1:0];
  endfunction

  // Steered wheel: angle atan(span/D) and spin hypot(span, D)*w/r.
  task automatic steered_wheel(input logic [SPAN_W-1:0] span, input longint n, input longint w,
                               input logic [DIST_W-1:0] r,
                               output logic [SPIN_W-1:0] spin,
                               output logic signed [STEER_W-1:0] ang, inout bit flt);
    longint along;
    longint unsigned ux, uy, m, h;
    int s;
    logic [STEER_W-1:0] mag_ang;
    along = longint'(span) * w;
    s = 0;
    if (n == 0) begin
      if (span == 0) begin
        spin = '0;
        ang  = '0;
        flt  = 1'b1;
      end else begin
        ang  = STEER_MAX;
        spin = radius_divide(along < 0 ? -along : along, along < 0, r, flt);
      end
      return;
    end
    ux = n < 0 ? -n : n;
    uy = along < 0 ? -along : along;
    m  = ux > uy ? ux : uy;
    while (m >= (64'd1 << 31)) begin
      ux = ux >> 1;
      uy = uy >> 1;
      m  = m >> 1;
      s++;
    end
    while (m < (64'd1 << 30)) begin
      ux = ux << 1;
      uy = uy << 1;
      m  = m << 1;
      s--;
    end
    h = floor_root(ux * ux + uy * uy);
    if (s > 0) h = h << s;
    else if (s < 0) h = h >> (-s);
    mag_ang = vector_angle(longint'(ux), longint'(uy));
    ang  = ((along < 0) != (n < 0)) ? -$signed(mag_ang) : $signed(mag_ang);
    spin = radius_divide(h, n < 0, r, flt);
  endtask

  // Full wheel set for one body command under the mirrored registers.
  task automatic predict_wheels(input logic signed [CMD_W-1:0] v_in,
                                input logic signed [CMD_W-1:0] w_in, output wheel_set_t ws);
    longint v, w;
    longint n [4];
    logic [DIST_W-1:0] span [4];
    logic [DIST_W-1:0] lat;
    bit flt;
    v   = longint'(v_in);
    w   = longint'(w_in);
    flt = 1'b0;
    for (int k = 0; k < 4; k++) begin
      span[k]     = geo_mirror[k][31:16];
      lat         = geo_mirror[k][15:0];
      n[k]        = (k % 2 == 1) ? v * 4096 + longint'(lat) * w : v * 4096 - longint'(lat) * w;
      ws.spin[k]  = '0;
      ws.steer[k] = '0;
    end
    if (mode_mirror != MODE_ALL && mode_mirror != MODE_FRONT) begin
      flt = 1'b1;
    end else if (w == 0) begin
      for (int k = 0; k < 4; k++) begin
        ws.spin[k] = radius_divide(v < 0 ? -v * 4096 : v * 4096, v < 0, radius_mirror, flt);
      end
    end else if (mode_mirror == MODE_ALL) begin
      for (int k = 0; k < 4; k++) begin
        steered_wheel({1'b0, span[k]}, n[k], w, radius_mirror, ws.spin[k], ws.steer[k], flt);
        if (k >= 2) ws.steer[k] = -ws.steer[k];
      end
    end else begin
      for (int k = 0; k < 2; k++) begin
        steered_wheel({1'b0, span[k]} + {1'b0, span[k+2]}, n[k], w, radius_mirror,
                      ws.spin[k], ws.steer[k], flt);
        ws.spin[k+2] = radius_divide(n[k+2] < 0 ? -n[k+2] : n[k+2], n[k+2] < 0,
                                     radius_mirror, flt);
      end
    end
    ws.fault = flt;
  endtask

  // Offer one request after a random gap, or none in steady flow, and queue its expected wheel set.
  task automatic send_command(input logic signed [CMD_W-1:0] v, input logic signed [CMD_W-1:0] w);
    int gap;
    wheel_set_t ws;
    gap = steady_flow ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_body_speed    <= v;
    in_body_yaw_rate <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_wheels(v, w, ws);
    pending_sets.push_back(ws);
  endtask

  // Wait until the pipeline has emptied, with the input channel quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_sets.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write one register and keep the mirror in step; the caller drops the enable.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GEO_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_MODE:   mode_mirror   = data[1:0];
      CFG_RADIUS: radius_mirror = data[DIST_W-1:0];
      CFG_GEO_FL: geo_mirror[0] = data;
      CFG_GEO_FR: geo_mirror[1] = data;
      CFG_GEO_RL: geo_mirror[2] = data;
      CFG_GEO_RR: geo_mirror[3] = data;
      default: ;
    endcase
  endtask

  // Write every register in one idle window.
  task automatic load_setting(input logic [1:0] mode, input logic [DIST_W-1:0] r,
                              input logic [GEO_W-1:0] fl, input logic [GEO_W-1:0] fr,
                              input logic [GEO_W-1:0] rl, input logic [GEO_W-1:0] rr);
    wait_idle();
    write_reg(CFG_MODE, {30'd0, mode});
    write_reg(CFG_RADIUS, {16'd0, r});
    write_reg(CFG_GEO_FL, fl);
    write_reg(CFG_GEO_FR, fr);
    write_reg(CFG_GEO_RL, rl);
    write_reg(CFG_GEO_RR, rr);
    cfg_we <= 1'b0;
  endtask

  // Command that puts one wheel on the turn center: v*4096 = -+lat*w.
  task automatic send_on_center(input int wheel, input int k);
    longint lat;
    lat = longint'(geo_mirror[wheel][15:0]);
    send_command(CMD_W'((wheel % 2 == 1) ? -lat * k : lat * k), 4096 * k);
  endtask

  // Random body command, mostly in a physical range, sometimes raw bits.
  task automatic send_random_command();
    int pick;
    logic signed [CMD_W-1:0] v, w;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      v = $urandom();
      w = $urandom();
    end else if (pick < 25) begin
      v = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      w = '0;
    end else if (pick < 35) begin
      send_on_center($urandom_range(0, 3), $urandom_range(1, 8) * ($urandom_range(0, 1) ? 1 : -1));
      return;
    end else if (pick < 65) begin
      v = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      w = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
    end else begin
      v = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
      w = $signed($urandom_range(0, 1 << 12)) - (1 << 11);
    end
    send_command(v, w);
  endtask

  task automatic send_random_batch(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 50) steady_flow = ~steady_flow;
      send_random_command();
    end
    steady_flow = 1'b0;
  endtask

  // Field extremes, straight driving and the turn-center cases at reset values.
  task automatic test_reset_defaults();
    send_command(0, 0);
    send_command(32'sh7FFF_FFFF, 0);
    send_command(32'sh8000_0000, 0);
    send_command(32'sh0001_0000, 32'sh0001_0000);
    send_command(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_command(32'sh8000_0000, 32'sh8000_0000);
    send_command(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_command(0, 32'sh0000_8000);
    send_command(32'sh0002_0000, -32'sh0000_4000);
    send_command(-32'sh0001_8000, 32'sh0000_0001);
    send_command(32'sh0000_0001, 32'sh7FFF_FFFF);
    send_on_center(0, 1);
    send_on_center(1, -2);
    send_on_center(2, 3);
    send_random_batch(150);
  endtask

  // All-wheel steering over changed geometry and radius extremes.
  task automatic test_all_wheel_steer();
    load_setting(MODE_ALL, 16'd1, 32'h1000_0800, 32'h2000_0400, 32'h0800_1000, 32'h0400_2000);
    send_random_batch(150);
    load_setting(MODE_ALL, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(32'sh7FFF_FFFF, 32'sh0000_0001);
    send_random_batch(150);
    // Zero span on every wheel: straight-ahead angles and zero over zero.
    load_setting(MODE_ALL, 16'd410, 32'h0000_04CD, 32'h0000_0000, 32'h0000_0800, 32'h0000_FFFF);
    send_on_center(0, 1);
    send_command(0, 32'sh0001_0000);
    send_random_batch(100);
  endtask

  // Front steering with fixed rear wheels.
  task automatic test_front_steer();
    load_setting(MODE_FRONT, 16'd410, GEO_RST, GEO_RST, GEO_RST, GEO_RST);
    send_on_center(0, 2);
    send_on_center(1, 1);
    send_random_batch(150);
    load_setting(MODE_FRONT, 16'd2048, 32'hFFFF_0100, 32'h0000_0200, 32'hFFFF_0300, 32'h0000_0000);
    send_on_center(1, -1);
    send_random_batch(150);
  endtask

  // Unknown drive modes and a zero wheel radius.
  task automatic test_fault_settings();
    load_setting(2'd0, 16'd410, GEO_RST, GEO_RST, GEO_RST, GEO_RST);
    send_random_batch(30);
    load_setting(2'd3, 16'd410, GEO_RST, GEO_RST, GEO_RST, GEO_RST);
    send_random_batch(30);
    load_setting(MODE_ALL, 16'd0, GEO_RST, GEO_RST, GEO_RST, GEO_RST);
    send_command(0, 0);
    send_random_batch(40);
    load_setting(MODE_FRONT, 16'd0, GEO_RST, GEO_RST, GEO_RST, GEO_RST);
    send_random_batch(40);
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    load_setting(MODE_ALL, RADIUS_RST, GEO_RST, 32'h0A00_0600, GEO_RST, 32'h0A00_0600);
    hold_request = 1'b1;
    steady_flow  = 1'b1;
    for (int i = 0; i < 200; i++) send_random_command();
    steady_flow = 1'b0;
    send_random_batch(60);
  endtask

  // Result side: random stalls per result, and one long hold-off on request.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_request = 1'b0;
      end
      stall = steady_flow ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    wheel_set_t ws;
    logic signed [SPIN_W-1:0]  got_spin [4];
    logic signed [STEER_W-1:0] got_steer [4];
    string wheel_name [4];
    wheel_name = '{"front_left", "front_right", "rear_left", "rear_right"};
    if (rst_n && out_valid && out_ready) begin
      if (pending_sets.size() == 0) begin
        $error("result with no request outstanding");
        mismatch_count++;
      end else begin
        ws = pending_sets.pop_front();
        got_spin  = '{out_front_left_spin, out_front_right_spin,
                      out_rear_left_spin, out_rear_right_spin};
        got_steer = '{out_front_left_steer, out_front_right_steer,
                      out_rear_left_steer, out_rear_right_steer};
        for (int k = 0; k < 4; k++) begin
          if (got_spin[k] !== ws.spin[k]) begin
            $error("%s_spin expected %0d actual %0d", wheel_name[k], ws.spin[k], got_spin[k]);
            mismatch_count++;
          end
          if (got_steer[k] !== ws.steer[k]) begin
            $error("%s_steer expected %0d actual %0d", wheel_name[k], ws.steer[k],
                   got_steer[k]);
            mismatch_count++;
          end
        end
        if (out_fault !== ws.fault) begin
          $error("fault expected %0d actual %0d", ws.fault, out_fault);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("wheel_speed_steer_distributor verification failed");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_body_speed    = '0;
    in_body_yaw_rate = '0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    mismatch_count   = 0;
    cycle_count      = 0;
    steady_flow      = 1'b0;
    hold_request     = 1'b0;
    mode_mirror      = MODE_RST;
    radius_mirror    = RADIUS_RST;
    for (int k = 0; k < 4; k++) geo_mirror[k] = GEO_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_all_wheel_steer();
    test_front_steer();
    test_fault_settings();
    test_backpressure();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("wheel_speed_steer_distributor verification clean");
    end else begin
      $display("wheel_speed_steer_distributor verification failed");
    end
    $finish;
  end

endmodule
